[sv/irfd_pkg.sv]
// ----------------------------------------------------------------------------
// irfd_pkg
// Types and constants shared by the IR remote frame decoder modules.
// ----------------------------------------------------------------------------
package irfd_pkg;

  // protocol codes
  localparam logic [1:0] PROTO_NONE = 2'd0;
  localparam logic [1:0] PROTO_RC5  = 2'd1;
  localparam logic [1:0] PROTO_NEC  = 2'd2;

  // window bounds in microseconds, both bounds exclusive
  localparam logic [15:0] RC5_SHORT_LO = 16'd780;
  localparam logic [15:0] RC5_SHORT_HI = 16'd1000;
  localparam logic [15:0] RC5_LONG_LO  = 16'd1628;
  localparam logic [15:0] RC5_LONG_HI  = 16'd1850;
  localparam logic [15:0] NEC_LEAD0_LO = 16'd3000;
  localparam logic [15:0] NEC_LEAD0_HI = 16'd26000;
  localparam logic [15:0] NEC_LEAD1_LO = 16'd4400;
  localparam logic [15:0] NEC_LEAD1_HI = 16'd4500;
  localparam logic [15:0] NEC_ONE_LO   = 16'd1600;
  localparam logic [15:0] NEC_ONE_HI   = 16'd1700;

  localparam int unsigned RC5_BITS = 14;

  typedef struct packed {
    logic signed [15:0] pulse_duration;
    logic               last_pulse;
  } in_t;

  typedef struct packed {
    logic [1:0] protocol;
    logic [2:0] rc5_header;
    logic [4:0] rc5_address;
    logic [5:0] rc5_command;
    logic [7:0] nec_address;
    logic [7:0] nec_address_second;
    logic [7:0] nec_command;
    logic [7:0] nec_command_inverted;
  } out_t;

  typedef struct packed {
    logic space;
    logic rc5_short;
    logic rc5_long;
    logic nec_one;
    logic nec_lead0;
    logic nec_lead1;
  } pulse_class_t;

endpackage

[sv/irfd_pulse_class.sv]
// ----------------------------------------------------------------------------
// irfd_pulse_class
// Sorts one signed pulse duration into the RC5 and NEC timing windows.
// ----------------------------------------------------------------------------
module irfd_pulse_class (
  input  logic signed [15:0]    pulse_duration_i,
  output irfd_pkg::pulse_class_t class_o
);

  logic [15:0] raw;
  logic        neg;
  logic [15:0] mag;

  assign raw = pulse_duration_i;
  assign neg = raw[15];
  // 0x8000 stays 0x8000 and so falls outside every window
  assign mag = neg ? 16'(~raw + 16'd1) : raw;

  assign class_o.space     = !neg && (raw != 16'd0);
  assign class_o.rc5_short = (mag > irfd_pkg::RC5_SHORT_LO) && (mag < irfd_pkg::RC5_SHORT_HI);
  assign class_o.rc5_long  = (mag > irfd_pkg::RC5_LONG_LO) && (mag < irfd_pkg::RC5_LONG_HI);
  assign class_o.nec_one   = (mag > irfd_pkg::NEC_ONE_LO) && (mag < irfd_pkg::NEC_ONE_HI);
  assign class_o.nec_lead0 = (mag > irfd_pkg::NEC_LEAD0_LO) && (mag < irfd_pkg::NEC_LEAD0_HI);
  assign class_o.nec_lead1 = (mag > irfd_pkg::NEC_LEAD1_LO) && (mag < irfd_pkg::NEC_LEAD1_HI);

endmodule

[sv/ir_remote_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ir_remote_frame_decoder_unit
// Decodes RC5 and NEC frames from a stream of signed pulse durations.
// ----------------------------------------------------------------------------
// path: the beat carrying last_pulse goes from the input register to the result register
// throughput: one pulse per cycle while out_valid_q is clear or out_ready_i is high, set by
//   the input register feeding the combinational frame update and the result register
// reset: rst_ni clears the pipeline valids and the frame state at once
// ----------------------------------------------------------------------------
module ir_remote_frame_decoder_unit #(
  parameter int unsigned FRAME_MAX = 70
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  irfd_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output irfd_pkg::out_t   out_data_o
);

  localparam int unsigned IdxW = $clog2(FRAME_MAX + 1);

  // input register
  logic          in_valid_q;
  irfd_pkg::in_t in_q;

  // frame state
  logic [IdxW-1:0] pulse_index_q, pulse_index_d;
  logic [7:0]      half_cnt_q, half_cnt_d;
  logic [3:0]      rc5_idx_q, rc5_idx_d;
  logic [13:0]     rc5_bits_q, rc5_bits_d;
  logic [31:0]     nec_bits_q, nec_bits_d;
  logic [1:0]      lead_ok_q, lead_ok_d;

  // result register
  logic           out_valid_q;
  irfd_pkg::out_t out_q, out_d;

  logic                   advance;
  logic                   overflow;
  logic                   emit;
  logic                   take_bit;
  logic [1:0]             half_add;
  logic [8:0]             half_sum;
  logic [3:0]             rc5_pos;
  logic [4:0]             nec_pos;
  logic [IdxW-1:0]        pulse_next;
  irfd_pkg::pulse_class_t cls;

  irfd_pulse_class u_class (
    .pulse_duration_i (in_q.pulse_duration),
    .class_o          (cls)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  assign overflow   = pulse_index_q >= IdxW'(FRAME_MAX);
  assign pulse_next = pulse_index_q + IdxW'(1);
  assign nec_pos    = 5'(pulse_index_q[IdxW-1:1] - (IdxW-1)'(1));
  assign rc5_pos    = 4'(irfd_pkg::RC5_BITS - 1) - rc5_idx_q;
  assign take_bit   = cls.rc5_long || (cls.rc5_short && half_cnt_q[0]);
  assign half_add   = cls.rc5_long ? 2'd2 : (cls.rc5_short ? 2'd1 : 2'd0);
  assign half_sum   = {1'b0, half_cnt_q} + {7'd0, half_add};
  assign emit       = !overflow && in_q.last_pulse;

  always_comb begin
    pulse_index_d = pulse_next;
    half_cnt_d    = half_sum[8] ? 8'hff : half_sum[7:0];
    rc5_idx_d     = rc5_idx_q;
    rc5_bits_d    = rc5_bits_q;
    nec_bits_d    = nec_bits_q;
    lead_ok_d     = lead_ok_q;

    if (pulse_index_q == IdxW'(0) && cls.nec_lead0) begin
      lead_ok_d[0] = 1'b1;
    end
    if (pulse_index_q == IdxW'(1) && cls.nec_lead1) begin
      lead_ok_d[1] = 1'b1;
    end
    if (pulse_index_q[0] && pulse_index_q >= IdxW'(3) && pulse_index_q <= IdxW'(65)
        && cls.nec_one) begin
      nec_bits_d = nec_bits_q | (32'd1 << nec_pos);
    end
    if (take_bit) begin
      if (rc5_idx_q < 4'(irfd_pkg::RC5_BITS) && cls.space) begin
        rc5_bits_d = rc5_bits_q | (14'd1 << rc5_pos);
      end
      if (rc5_idx_q != 4'd15) begin
        rc5_idx_d = rc5_idx_q + 4'd1;
      end
    end

    // result from the state after this pulse
    out_d = '0;
    if (pulse_next >= IdxW'(16) && pulse_next <= IdxW'(28)
        && (half_cnt_d == 8'd27 || half_cnt_d == 8'd28)) begin
      out_d.protocol    = irfd_pkg::PROTO_RC5;
      out_d.rc5_header  = rc5_bits_d[13:11];
      out_d.rc5_address = rc5_bits_d[10:6];
      out_d.rc5_command = rc5_bits_d[5:0];
    end else if (lead_ok_d == 2'b11) begin
      out_d.protocol             = irfd_pkg::PROTO_NEC;
      out_d.nec_address          = nec_bits_d[7:0];
      out_d.nec_address_second   = nec_bits_d[15:8];
      out_d.nec_command          = nec_bits_d[23:16];
      out_d.nec_command_inverted = nec_bits_d[31:24];
    end else begin
      out_d.protocol = irfd_pkg::PROTO_NONE;
    end

    // overflow and end of frame both return to the idle frame
    if (overflow || in_q.last_pulse) begin
      pulse_index_d = '0;
      half_cnt_d    = 8'd1;
      rc5_idx_d     = '0;
      rc5_bits_d    = '0;
      nec_bits_d    = '0;
      lead_ok_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_index_q <= '0;
      half_cnt_q    <= 8'd1;
      rc5_idx_q     <= '0;
      rc5_bits_q    <= '0;
      nec_bits_q    <= '0;
      lead_ok_q     <= '0;
    end else if (advance) begin
      pulse_index_q <= pulse_index_d;
      half_cnt_q    <= half_cnt_d;
      rc5_idx_q     <= rc5_idx_d;
      rc5_bits_q    <= rc5_bits_d;
      nec_bits_q    <= nec_bits_d;
      lead_ok_q     <= lead_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
